// ----- sv/assert_macros.svh -----
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/owm_pkg.sv -----
package owm_pkg;

	localparam int TIMER_BITS = 10;
	localparam int CFG_W      = 10;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [CFG_W-1:0]      cfg_word_t;

	typedef enum logic [1:0] {
		FN_TICK  = 2'd0,
		FN_RESET = 2'd1,
		FN_WRITE = 2'd2,
		FN_READ  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_RLOW  = 3'd1,
		PH_RWAIT = 3'd2,
		PH_RREC  = 3'd3,
		PH_WRITE = 3'd4,
		PH_READ  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		REG_RESET_LOW    = 3'd0,
		REG_PRESENCE_WT  = 3'd1,
		REG_RESET_REC    = 3'd2,
		REG_START_LOW    = 3'd3,
		REG_WR_ZERO_LOW  = 3'd4,
		REG_WR_SLOT      = 3'd5,
		REG_RD_SAMPLE    = 3'd6,
		REG_RD_SLOT      = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		cfg_word_t reset_low_time;
		cfg_word_t presence_wait;
		cfg_word_t reset_recovery;
		cfg_word_t start_low_time;
		cfg_word_t write_zero_low;
		cfg_word_t write_slot;
		cfg_word_t read_sample_time;
		cfg_word_t read_slot;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		reset_low_time:   10'd602,
		presence_wait:    10'd58,
		reset_recovery:   10'd400,
		start_low_time:   10'd2,
		write_zero_low:   10'd56,
		write_slot:       10'd60,
		read_sample_time: 10'd12,
		read_slot:        10'd61
	};

	typedef struct packed {
		func_t      func;
		logic [7:0] data_byte;
		logic       line_in;
	} item_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_value;
		logic       rejected;
	} result_t;

	function automatic cfg_word_t at_least_one(input cfg_word_t v);
		return (v == '0) ? cfg_word_t'(1) : v;
	endfunction

endpackage

// ----- sv/owm_ifs.sv -----
interface owm_cmd_if;
	import owm_pkg::*;
	logic       valid;
	logic       ready;
	func_t      func;
	logic [7:0] data_byte;
	logic       line_in;

	modport source(output valid, output func, output data_byte, output line_in, input ready);
	modport sink(input valid, input func, input data_byte, input line_in, output ready);
endinterface

interface owm_res_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic       presence;
	logic [7:0] read_value;
	logic       rejected;

	modport source(output valid, output drive_low, output busy_res, output done_res,
		output presence, output read_value, output rejected, input ready);
	modport sink(input valid, input drive_low, input busy_res, input done_res,
		input presence, input read_value, input rejected, output ready);
endinterface

// ----- sv/owm_core.sv -----
module owm_core
	import owm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	phase_t     phase_q, phase_d;
	timer_t     timer_q, timer_d;
	logic [3:0] bits_q, bits_d;
	logic [7:0] shift_q, shift_d;
	logic       pres_q, pres_d;
	logic       released_q, released_d;
	logic [7:0] last_q, last_d;

	timer_t     nt;
	cfg_word_t  wr_low;
	cfg_word_t  rd_len;
	cfg_word_t  rd_smp;
	logic [3:0] bits_dec;
	logic       drive;
	logic       done;
	logic       rej;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			timer_q    <= '0;
			bits_q     <= '0;
			shift_q    <= '0;
			pres_q     <= 1'b0;
			released_q <= 1'b1;
			last_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			timer_q    <= timer_d;
			bits_q     <= bits_d;
			shift_q    <= shift_d;
			pres_q     <= pres_d;
			released_q <= released_d;
			last_q     <= last_d;
		end
	end

	always_comb begin
		nt       = timer_t'(timer_q + timer_t'(1));
		wr_low   = shift_q[0] ? cfg.start_low_time : cfg.write_zero_low;
		rd_len   = at_least_one(cfg.read_slot);
		rd_smp   = (cfg.read_sample_time == '0) ? '0
			: cfg_word_t'(cfg.read_sample_time - cfg_word_t'(1));
		if (rd_smp > cfg_word_t'(rd_len - cfg_word_t'(1)))
			rd_smp = cfg_word_t'(rd_len - cfg_word_t'(1));
		bits_dec = 4'(bits_q - 4'd1);

		phase_d    = phase_q;
		timer_d    = timer_q;
		bits_d     = bits_q;
		shift_d    = shift_q;
		pres_d     = pres_q;
		released_d = released_q;
		last_d     = last_q;
		drive      = 1'b0;
		done       = 1'b0;
		rej        = 1'b0;

		if (item.func != FN_TICK) begin
			drive = !released_q;
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				timer_d = '0;
				case (item.func)
					FN_RESET: begin
						phase_d = PH_RLOW;
					end
					FN_WRITE: begin
						phase_d = PH_WRITE;
						bits_d  = 4'd8;
						shift_d = item.data_byte;
					end
					default: begin
						phase_d = PH_READ;
						bits_d  = 4'd8;
						shift_d = '0;
					end
				endcase
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					drive   = 1'b0;
				end
				PH_RLOW: begin
					drive   = 1'b1;
					timer_d = nt;
					if (nt >= timer_t'(at_least_one(cfg.reset_low_time))) begin
						phase_d = PH_RWAIT;
						timer_d = '0;
					end
				end
				PH_RWAIT: begin
					timer_d = nt;
					if (nt >= timer_t'(at_least_one(cfg.presence_wait))) begin
						pres_d  = !item.line_in;
						timer_d = '0;
						if (cfg.reset_recovery == '0) begin
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							phase_d = PH_RREC;
						end
					end
				end
				PH_RREC: begin
					timer_d = nt;
					if (nt >= timer_t'(cfg.reset_recovery)) begin
						phase_d = PH_IDLE;
						done    = 1'b1;
						timer_d = '0;
					end
				end
				PH_WRITE: begin
					drive   = timer_q < timer_t'(wr_low);
					timer_d = nt;
					if (nt >= timer_t'(at_least_one(cfg.write_slot))) begin
						timer_d = '0;
						shift_d = {1'b0, shift_q[7:1]};
						bits_d  = bits_dec;
						if (bits_dec == '0) begin
							phase_d = PH_IDLE;
							done    = 1'b1;
						end
					end
				end
				PH_READ: begin
					drive   = timer_q < timer_t'(cfg.start_low_time);
					timer_d = nt;
					if (timer_q == timer_t'(rd_smp))
						shift_d = {item.line_in, shift_q[7:1]};
					if (nt >= timer_t'(rd_len)) begin
						timer_d = '0;
						bits_d  = bits_dec;
						if (bits_dec == '0) begin
							phase_d = PH_IDLE;
							done    = 1'b1;
							last_d  = shift_d;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
					timer_d = '0;
				end
			endcase
			released_d = !drive;
		end

		res.drive_low  = drive;
		res.busy_res   = phase_d != PH_IDLE;
		res.done_res   = done;
		res.presence   = pres_d;
		res.read_value = last_d;
		res.rejected   = rej;
	end

endmodule

// ----- sv/one_wire_master_timing.sv -----
// 1-wire bus master timed by one-microsecond tick beats. A command beat (reset,
// write byte, read byte) starts an operation; every tick beat returns the open-drain
// drive level for that microsecond plus busy, done, presence, read byte and reject
// flags. Every command or tick beat yields exactly one result beat. The block takes
// one beat per clock while the result side is not stalled by res.ready; a beat
// passes through the input register and then the result register, which is loaded
// by the single state update per beat. Slot timings come from eight 10-bit registers
// written through cfg_we/cfg_index/cfg_wdata; the user must write them only while
// no operation is running, which the block itself does not enforce.
`include "assert_macros.svh"

module one_wire_master_timing
	import owm_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	owm_cmd_if.sink         cmd,
	owm_res_if.source       res,
	input  logic            cfg_we,
	input  cfg_idx_t        cfg_index,
	input  cfg_word_t       cfg_wdata
);

	cfg_t    cfg_q;
	logic    item_valid_s1;
	item_t   item_s1;
	logic    res_valid_q;
	result_t res_q;
	result_t core_res;
	logic    advance;

	assign advance   = item_valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESET_LOW:   cfg_q.reset_low_time   <= cfg_wdata;
				REG_PRESENCE_WT: cfg_q.presence_wait    <= cfg_wdata;
				REG_RESET_REC:   cfg_q.reset_recovery   <= cfg_wdata;
				REG_START_LOW:   cfg_q.start_low_time   <= cfg_wdata;
				REG_WR_ZERO_LOW: cfg_q.write_zero_low   <= cfg_wdata;
				REG_WR_SLOT:     cfg_q.write_slot       <= cfg_wdata;
				REG_RD_SAMPLE:   cfg_q.read_sample_time <= cfg_wdata;
				REG_RD_SLOT:     cfg_q.read_slot        <= cfg_wdata;
				default:         cfg_q                  <= cfg_q;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			item_valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.func      <= cmd.func;
			item_s1.data_byte <= cmd.data_byte;
			item_s1.line_in   <= cmd.line_in;
		end
	end

	owm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (core_res)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= core_res;
	end

	assign res.valid      = res_valid_q;
	assign res.drive_low  = res_q.drive_low;
	assign res.busy_res   = res_q.busy_res;
	assign res.done_res   = res_q.done_res;
	assign res.presence   = res_q.presence;
	assign res.read_value = res_q.read_value;
	assign res.rejected   = res_q.rejected;

	`ASSERT_IMPL(a_done_not_busy, clk, arst_n, res_valid_q && res_q.done_res,
		!res_q.busy_res, "done beat still busy")
	`ASSERT_IMPL(a_reject_not_done, clk, arst_n, res_valid_q && res_q.rejected,
		!res_q.done_res && res_q.busy_res, "rejected beat finished an operation")
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, item_valid_s1 && !advance,
		item_valid_s1 && $stable(item_s1), "input stage lost a stalled beat")

endmodule
